// ----- sv/ett_pkg.sv -----
// ============================================================================
// Entity text tokenizer package
// Shared types and constants for the entity lump tokenizer: event codes,
// character codes, the classified byte passed from front to back, and the
// result item.
// ============================================================================
package ett_pkg;

    // Event codes reported with every byte.
    typedef enum logic [2:0] {
        EV_IGNORED     = 3'd0,
        EV_OPEN        = 3'd1,
        EV_KEY_CHAR    = 3'd2,
        EV_KEY_DONE    = 3'd3,
        EV_VALUE_CHAR  = 3'd4,
        EV_PROP_DONE   = 3'd5,
        EV_ENTITY_DONE = 3'd6,
        EV_HALTED      = 3'd7
    } t_event;

    // Delimiter characters of the lump syntax.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;

    // Saturation limits of the reported fields.
    localparam logic [7:0]  KEY_LEN_MAX   = 8'hFF;
    localparam logic [11:0] VALUE_LEN_MAX = 12'hFFF;
    localparam logic [15:0] TOTAL_MAX     = 16'hFFFF;

    // Depth of the queue between front and back.
    localparam int Q_DEPTH = 2;

    // A byte after classification in the front part.
    typedef struct packed {
        logic       restart;
        logic       is_nul;
        logic       is_lbrace;
        logic       is_rbrace;
        logic       is_quote;
        logic [7:0] ch;
    } t_cls;

endpackage

// ----- sv/ett_if.sv -----
// ============================================================================
// Entity text tokenizer channels
// Valid/ready channels for input bytes and for result items.
// ============================================================================

// Input channel: one lump byte per item.
interface ett_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       restart;

    modport source (output valid, output ch, output restart, input ready);
    modport sink   (input valid, input ch, input restart, output ready);
endinterface

// Output channel: one event per item.
interface ett_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_res;
    logic [7:0]  data_byte;
    logic [7:0]  key_length;
    logic [11:0] value_length;
    logic [15:0] property_total;
    logic [15:0] entity_total;

    modport source (output valid, output event_res, output data_byte,
                    output key_length, output value_length,
                    output property_total, output entity_total, input ready);
    modport sink   (input valid, input event_res, input data_byte,
                    input key_length, input value_length,
                    input property_total, input entity_total, output ready);
endinterface

// ----- sv/entity_text_tokenizer_unit.sv -----
// Path: a byte accepted from the input channel is registered in the front end, written
// into the queue and carried out by the parse engine into the result register.
// Throughput: one byte per cycle while results are taken; parse state is registered.
// A two-entry queue between front end and parse engine absorbs short output stalls.
// Reset (synchronous, active low) empties all stages and sets the parse outside
// any entity with all counts at zero; a restart byte resets the parse and counts in-band.
// ============================================================================
// Entity text tokenizer
// Streaming tokenizer for the entity text lump: a front end classifies
// bytes, a short queue decouples it from the parse engine, which emits one
// event per byte with running counts.
// ============================================================================
module entity_text_tokenizer_unit
    import ett_pkg::*;
#(
    parameter int KEY_BUF   = 256,
    parameter int VALUE_BUF = 4096
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    ett_in_if.sink    i_item,
    ett_out_if.source o_result
);

    logic front_valid;
    logic front_ready;
    t_cls front_cls;
    logic q_valid;
    logic q_ready;
    t_cls q_cls;

    // Front end: accept and classify.
    ett_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .o_valid (front_valid),
        .o_cls   (front_cls),
        .i_ready (front_ready)
    );

    // Queue between front end and parse engine.
    ett_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .i_cls   (front_cls),
        .o_ready (front_ready),
        .o_valid (q_valid),
        .o_cls   (q_cls),
        .i_ready (q_ready)
    );

    // Parse engine and result register.
    ett_back #(
        .KEY_BUF   (KEY_BUF),
        .VALUE_BUF (VALUE_BUF)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_cls    (q_cls),
        .o_ready  (q_ready),
        .o_result (o_result)
    );

endmodule

// ----- sv/ett_front.sv -----
// ============================================================================
// Tokenizer front end
// Accepts lump bytes, classifies them against the delimiter characters and
// registers the classified item for the queue.
// ============================================================================
module ett_front
    import ett_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    ett_in_if.sink    i_item,
    output logic      o_valid,
    output t_cls      o_cls,
    input  logic      i_ready
);

    logic r_valid;
    t_cls r_cls;
    t_cls n_cls;
    logic take;

    // The stage takes a new item when empty or when its item moves on.
    assign i_item.ready = !r_valid || i_ready;
    assign take         = i_item.valid && i_item.ready;

    // Classify the byte.
    always_comb begin
        n_cls.restart   = i_item.restart;
        n_cls.is_nul    = (i_item.ch == CH_NUL);
        n_cls.is_lbrace = (i_item.ch == CH_LBRACE);
        n_cls.is_rbrace = (i_item.ch == CH_RBRACE);
        n_cls.is_quote  = (i_item.ch == CH_QUOTE);
        n_cls.ch        = i_item.ch;
    end

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_valid <= i_item.valid;
        end
    end

    // Payload register.
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cls <= n_cls;
        end
    end

    assign o_valid = r_valid;
    assign o_cls   = r_cls;

endmodule

// ----- sv/ett_fifo.sv -----
// ============================================================================
// Tokenizer queue
// Short first-in first-out queue of classified bytes between the front end
// and the parse engine.
// ============================================================================
module ett_fifo
    import ett_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_cls i_cls,
    output logic o_ready,
    output logic o_valid,
    output t_cls o_cls,
    input  logic i_ready
);

    localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CW = $clog2(Q_DEPTH + 1);

    t_cls          r_mem [Q_DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          push;
    logic          pop;

    assign o_ready = (r_count != CW'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cls   = r_mem[r_rd_ptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    // Storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_cls;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // The fill count never passes the depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(Q_DEPTH))
        else $error("queue fill count exceeds depth");

    // A full queue refuses new items.
    a_full_no_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == CW'(Q_DEPTH)) |-> !push)
        else $error("push into a full queue");

    // Without push or pop the fill count holds.
    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!push && !pop) |=> $stable(r_count))
        else $error("queue fill count changed while idle");

endmodule

// ----- sv/ett_back.sv -----
// ============================================================================
// Tokenizer parse engine
// Holds the parse mode and counts, carries out one classified byte per cycle
// while the output register is free or drains, and registers the event.
// ============================================================================
module ett_back
    import ett_pkg::*;
#(
    parameter int KEY_BUF   = 256,
    parameter int VALUE_BUF = 4096
)
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_cls     i_cls,
    output logic     o_ready,
    ett_out_if.source o_result
);

    localparam int KW = $clog2(KEY_BUF);
    localparam int VW = $clog2(VALUE_BUF);

    typedef enum logic [2:0] {
        S_OUTSIDE,
        S_ENTITY,
        S_KEY,
        S_WAIT,
        S_VALUE,
        S_HALTED
    } t_mode;

    t_mode         r_mode,     n_mode, mode_in;
    logic [KW-1:0] r_key_cnt,  n_key_cnt, key_in;
    logic [VW-1:0] r_val_cnt,  n_val_cnt, val_in;
    logic [15:0]   r_prop_cnt, n_prop_cnt, prop_in;
    logic [15:0]   r_ent_cnt,  n_ent_cnt, ent_in;
    t_event        n_event;
    logic [7:0]    n_data;
    logic [7:0]    key_len;
    logic [11:0]   val_len;

    logic          r_out_valid;
    t_event        r_event;
    logic [7:0]    r_data;
    logic [7:0]    r_key_len;
    logic [11:0]   r_val_len;
    logic [15:0]   r_prop_tot;
    logic [15:0]   r_ent_tot;
    logic          step;

    // A byte is carried out whenever the output register is free or drains.
    assign o_ready = !r_out_valid || o_result.ready;
    assign step    = i_valid && o_ready;

    // A restart clears the state before the byte is parsed.
    always_comb begin
        mode_in = i_cls.restart ? S_OUTSIDE : r_mode;
        key_in  = i_cls.restart ? '0 : r_key_cnt;
        val_in  = i_cls.restart ? '0 : r_val_cnt;
        prop_in = i_cls.restart ? '0 : r_prop_cnt;
        ent_in  = i_cls.restart ? '0 : r_ent_cnt;
    end

    // Parse step.
    always_comb begin
        n_mode     = mode_in;
        n_key_cnt  = key_in;
        n_val_cnt  = val_in;
        n_prop_cnt = prop_in;
        n_ent_cnt  = ent_in;
        n_event    = EV_IGNORED;
        n_data     = 8'h00;
        if (i_cls.is_nul || mode_in == S_HALTED) begin
            n_mode  = S_HALTED;
            n_event = EV_HALTED;
        end else begin
            unique case (mode_in)
                S_OUTSIDE: begin
                    if (i_cls.is_lbrace) begin
                        n_mode     = S_ENTITY;
                        n_prop_cnt = '0;
                        n_event    = EV_OPEN;
                    end
                end
                S_ENTITY: begin
                    if (i_cls.is_quote) begin
                        n_mode    = S_KEY;
                        n_key_cnt = '0;
                    end else if (i_cls.is_rbrace) begin
                        n_mode    = S_OUTSIDE;
                        n_ent_cnt = (ent_in == TOTAL_MAX) ? TOTAL_MAX : ent_in + 16'd1;
                        n_event   = EV_ENTITY_DONE;
                    end
                end
                S_KEY: begin
                    if (key_in >= KW'(KEY_BUF - 1) || i_cls.is_quote) begin
                        n_mode  = S_WAIT;
                        n_event = EV_KEY_DONE;
                    end else begin
                        n_key_cnt = key_in + 1'b1;
                        n_event   = EV_KEY_CHAR;
                        n_data    = i_cls.ch;
                    end
                end
                S_WAIT: begin
                    if (i_cls.is_quote) begin
                        n_mode    = S_VALUE;
                        n_val_cnt = '0;
                    end
                end
                S_VALUE: begin
                    if (val_in >= VW'(VALUE_BUF - 1) || i_cls.is_quote) begin
                        n_mode     = S_ENTITY;
                        n_prop_cnt = (prop_in == TOTAL_MAX) ? TOTAL_MAX
                                                            : prop_in + 16'd1;
                        n_event    = EV_PROP_DONE;
                    end else begin
                        n_val_cnt = val_in + 1'b1;
                        n_event   = EV_VALUE_CHAR;
                        n_data    = i_cls.ch;
                    end
                end
                default: begin
                    n_mode  = S_HALTED;
                    n_event = EV_HALTED;
                end
            endcase
        end
    end

    // Clamp the internal counts to the reported field widths.
    generate
        if (KW > 8) begin : g_key_sat
            assign key_len = (n_key_cnt > KW'(KEY_LEN_MAX)) ? KEY_LEN_MAX
                                                            : n_key_cnt[7:0];
        end else begin : g_key_ext
            assign key_len = 8'(n_key_cnt);
        end
        if (VW > 12) begin : g_val_sat
            assign val_len = (n_val_cnt > VW'(VALUE_LEN_MAX)) ? VALUE_LEN_MAX
                                                              : n_val_cnt[11:0];
        end else begin : g_val_ext
            assign val_len = 12'(n_val_cnt);
        end
    endgenerate

    // Parse state and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= S_OUTSIDE;
            r_key_cnt   <= '0;
            r_val_cnt   <= '0;
            r_prop_cnt  <= '0;
            r_ent_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (step) begin
                r_mode     <= n_mode;
                r_key_cnt  <= n_key_cnt;
                r_val_cnt  <= n_val_cnt;
                r_prop_cnt <= n_prop_cnt;
                r_ent_cnt  <= n_ent_cnt;
            end
            if (o_ready) begin
                r_out_valid <= i_valid;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_event    <= n_event;
            r_data     <= n_data;
            r_key_len  <= key_len;
            r_val_len  <= val_len;
            r_prop_tot <= n_prop_cnt;
            r_ent_tot  <= n_ent_cnt;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.event_res      = r_event;
    assign o_result.data_byte      = r_data;
    assign o_result.key_length     = r_key_len;
    assign o_result.value_length   = r_val_len;
    assign o_result.property_total = r_prop_tot;
    assign o_result.entity_total   = r_ent_tot;

    // A halted parse stays halted until a restart arrives.
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && r_mode == S_HALTED && !i_cls.restart) |=> (r_mode == S_HALTED))
        else $error("parse left halted mode without restart");

    // Entity count never drops unless a restart clears it.
    a_ent_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step && !i_cls.restart) |=> (r_ent_cnt >= $past(r_ent_cnt)))
        else $error("entity count decreased without restart");

    // A key character event always reports a nonzero key length.
    a_key_char_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_event == EV_KEY_CHAR) |-> (r_key_len != 8'h00))
        else $error("key char event with zero key length");

    // The data byte is zero on every event that carries no character.
    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_event != EV_KEY_CHAR && r_event != EV_VALUE_CHAR)
        |-> (r_data == 8'h00))
        else $error("data byte set on a non-character event");

endmodule

// ----- dv/entity_text_tokenizer_unit_checker.sv -----
`timescale 1ns / 1ps
// ============================================================================
// Entity text tokenizer checker
// Watches the byte and event channels. It keeps its own model of the parse
// state and counts, predicts one event for every accepted byte, and compares
// each accepted result item, field by field, with the oldest prediction.
// ============================================================================
module entity_text_tokenizer_unit_checker
    import ett_pkg::*;
#(
    parameter int KEY_BUF   = 256,
    parameter int VALUE_BUF = 4096
)
(
    input  logic i_clk,
    input  logic i_rst_n,
    ett_in_if    i_item,
    ett_out_if   i_result,
    output int   o_fail_count,
    output int   o_pending
);

    // Parse modes of the model.
    typedef enum logic [2:0] {
        PS_OUTSIDE,
        PS_ENTITY,
        PS_KEY,
        PS_WAIT,
        PS_VALUE,
        PS_HALTED
    } t_parse_state;

    // One predicted or observed event with its running counts.
    typedef struct packed {
        t_event      ev;
        logic [7:0]  data;
        logic [7:0]  key_len;
        logic [11:0] val_chars;
        logic [15:0] prop_total;
        logic [15:0] ent_total;
    } t_token_event;

    t_parse_state   parse_state;
    int             key_cnt;
    int             value_cnt;
    logic [15:0]    prop_cnt;
    logic [15:0]    ent_cnt;
    t_token_event   pending_events[$];
    int             n_results;

    // Return the model to the state after reset or after a restart byte.
    function automatic void clear_parse();
        parse_state = PS_OUTSIDE;
        key_cnt     = 0;
        value_cnt   = 0;
        prop_cnt    = '0;
        ent_cnt     = '0;
    endfunction

    // Advance the model by one byte and return the event it produces.
    function automatic t_token_event tokenize_byte(input logic [7:0] c, input logic rs);
        t_token_event r;
        r    = '0;
        r.ev = EV_IGNORED;
        if (rs) begin
            clear_parse();
        end
        if (parse_state == PS_HALTED || c == CH_NUL) begin
            parse_state = PS_HALTED;
            r.ev        = EV_HALTED;
        end else begin
            case (parse_state)
                PS_OUTSIDE: begin
                    if (c == CH_LBRACE) begin
                        parse_state = PS_ENTITY;
                        prop_cnt    = '0;
                        r.ev        = EV_OPEN;
                    end
                end
                PS_ENTITY: begin
                    if (c == CH_QUOTE) begin
                        parse_state = PS_KEY;
                        key_cnt     = 0;
                    end else if (c == CH_RBRACE) begin
                        parse_state = PS_OUTSIDE;
                        if (ent_cnt != TOTAL_MAX) ent_cnt++;
                        r.ev = EV_ENTITY_DONE;
                    end
                end
                PS_KEY: begin
                    // A full key drops the arriving byte, even a quote.
                    if (key_cnt >= KEY_BUF - 1 || c == CH_QUOTE) begin
                        parse_state = PS_WAIT;
                        r.ev        = EV_KEY_DONE;
                    end else begin
                        key_cnt++;
                        r.ev   = EV_KEY_CHAR;
                        r.data = c;
                    end
                end
                PS_WAIT: begin
                    if (c == CH_QUOTE) begin
                        parse_state = PS_VALUE;
                        value_cnt   = 0;
                    end
                end
                default: begin
                    // A full value ends the property the same way.
                    if (value_cnt >= VALUE_BUF - 1 || c == CH_QUOTE) begin
                        parse_state = PS_ENTITY;
                        if (prop_cnt != TOTAL_MAX) prop_cnt++;
                        r.ev = EV_PROP_DONE;
                    end else begin
                        value_cnt++;
                        r.ev   = EV_VALUE_CHAR;
                        r.data = c;
                    end
                end
            endcase
        end
        r.key_len    = (key_cnt > KEY_LEN_MAX) ? KEY_LEN_MAX : 8'(key_cnt);
        r.val_chars  = (value_cnt > VALUE_LEN_MAX) ? VALUE_LEN_MAX : 12'(value_cnt);
        r.prop_total = prop_cnt;
        r.ent_total  = ent_cnt;
        return r;
    endfunction

    // Print one mismatch line and count it.
    task automatic report_mismatch(input string msg);
        $display("ERROR: [%0t] result %0d: %s", $time, n_results, msg);
        o_fail_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got_v,
                               input logic [15:0] want_v);
        if (got_v !== want_v) begin
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got_v, want_v));
        end
    endtask

    // Predict on accepted bytes and compare on accepted result items.
    always @(posedge i_clk) begin
        t_token_event got;
        t_token_event want;
        if (!i_rst_n) begin
            clear_parse();
            pending_events.delete();
            n_results = 0;
        end else begin
            if (i_item.valid && i_item.ready) begin
                pending_events.push_back(tokenize_byte(i_item.ch, i_item.restart));
            end
            if (i_result.valid && i_result.ready) begin
                got.ev         = t_event'(i_result.event_res);
                got.data       = i_result.data_byte;
                got.key_len    = i_result.key_length;
                got.val_chars  = i_result.value_length;
                got.prop_total = i_result.property_total;
                got.ent_total  = i_result.entity_total;
                if (pending_events.size() == 0) begin
                    report_mismatch($sformatf("unexpected item, event %0d", got.ev));
                end else begin
                    want = pending_events.pop_front();
                    check_field("event_res", 16'(got.ev), 16'(want.ev));
                    check_field("data_byte", 16'(got.data), 16'(want.data));
                    check_field("key_length", 16'(got.key_len), 16'(want.key_len));
                    check_field("value_length", 16'(got.val_chars), 16'(want.val_chars));
                    check_field("property_total", got.prop_total, want.prop_total);
                    check_field("entity_total", got.ent_total, want.ent_total);
                end
                n_results++;
            end
        end
        o_pending <= pending_events.size();
    end

endmodule

// ----- dv/entity_text_tokenizer_unit_tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// Entity text tokenizer testbench
// Feeds directed and random entity lump bytes (well-formed lumps with random
// text, long keys, halts, restarts and raw noise) under changing idle
// patterns on both channels. The checker beside the block predicts every
// event.
// ============================================================================
module entity_text_tokenizer_unit_tb;
    import ett_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int N_RANDOM   = 1200;
    localparam int N_DIRECTED = 24;

    // Directed bytes: restart flag over the character.
    localparam logic [8:0] DIRECTED [N_DIRECTED] = '{
        {1'b1, CH_LBRACE}, {1'b0, CH_QUOTE},  {1'b0, 8'h01},     {1'b0, 8'hFF},
        {1'b0, CH_QUOTE},  {1'b0, 8'h41},     {1'b0, CH_QUOTE},  {1'b0, CH_LBRACE},
        {1'b0, 8'h80},     {1'b0, CH_QUOTE},  {1'b0, CH_QUOTE},  {1'b0, CH_QUOTE},
        {1'b0, CH_QUOTE},  {1'b0, CH_QUOTE},  {1'b0, 8'h7E},     {1'b0, CH_RBRACE},
        {1'b0, 8'h55},     {1'b0, CH_RBRACE}, {1'b0, CH_QUOTE},  {1'b0, CH_NUL},
        {1'b0, CH_LBRACE}, {1'b1, CH_NUL},    {1'b1, CH_LBRACE}, {1'b0, CH_RBRACE}
    };

    logic       clk;
    logic       rst_n       = 1'b0;
    logic       snd_valid   = 1'b0;
    logic [7:0] snd_ch      = 8'h00;
    logic       snd_restart = 1'b0;
    logic       rcv_ready   = 1'b0;
    logic       restart_next = 1'b0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int n_sent        = 0;
    int stall_cycles  = 0;
    int fail_count;
    int pending;

    ett_in_if  in_ch();
    ett_out_if out_ch();

    assign in_ch.valid   = snd_valid;
    assign in_ch.ch      = snd_ch;
    assign in_ch.restart = snd_restart;
    assign out_ch.ready  = rcv_ready;

    entity_text_tokenizer_unit u_top (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_item   (in_ch),
        .o_result (out_ch)
    );

    entity_text_tokenizer_unit_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_item       (in_ch),
        .i_result     (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Free-running clock.
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result receiver with random stalls.
    always @(posedge clk) begin
        rcv_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog on cycles in which no item moves on either channel.
    always @(posedge clk) begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Offer one byte, idling first at random, and wait until it is taken.
    task automatic send_byte(input logic [7:0] c);
        while ($urandom_range(99) < send_idle_pct) begin
            snd_valid <= 1'b0;
            @(posedge clk);
        end
        snd_valid    <= 1'b1;
        snd_ch       <= c;
        snd_restart  <= restart_next;
        restart_next = 1'b0;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        n_sent++;
    endtask

    // Random nonzero byte that differs from two delimiters.
    function automatic logic [7:0] rand_other(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255)); while (c == a || c == b);
        return c;
    endfunction

    task automatic send_text(input int n);
        repeat (n) send_byte(rand_other(CH_QUOTE, CH_QUOTE));
    endtask

    // One lump: mostly well-formed entities with random content, sometimes
    // raw noise. A forced length of zero or more applies to the first property.
    task automatic send_lump(input int key_force, input int value_force);
        int n_ent;
        int n_prop;
        int klen;
        int vlen;
        logic [7:0] c;
        restart_next = 1'b1;
        if (key_force < 0 && value_force < 0 && $urandom_range(9) == 0) begin
            // Broken lump: delimiters, zero bytes and noise, stray restarts.
            repeat ($urandom_range(5, 30)) begin
                case ($urandom_range(7))
                    0: c = CH_LBRACE;
                    1: c = CH_RBRACE;
                    2: c = CH_QUOTE;
                    3: c = ($urandom_range(3) == 0) ? CH_NUL : CH_QUOTE;
                    default: c = 8'($urandom_range(255));
                endcase
                if ($urandom_range(15) == 0) restart_next = 1'b1;
                send_byte(c);
            end
        end else begin
            if ($urandom_range(1) == 0) send_byte(rand_other(CH_LBRACE, CH_LBRACE));
            n_ent = $urandom_range(1, 4);
            for (int e = 0; e < n_ent; e++) begin
                send_byte(CH_LBRACE);
                n_prop = $urandom_range(0, 3);
                if (n_prop == 0 && (key_force >= 0 || value_force >= 0)) n_prop = 1;
                for (int p = 0; p < n_prop; p++) begin
                    if ($urandom_range(3) == 0) send_byte(rand_other(CH_QUOTE, CH_RBRACE));
                    if (key_force >= 0) klen = key_force;
                    else if ($urandom_range(39) == 0) klen = $urandom_range(250, 258);
                    else klen = $urandom_range(0, 10);
                    if (value_force >= 0) vlen = value_force;
                    else vlen = $urandom_range(0, 16);
                    key_force   = -1;
                    value_force = -1;
                    send_byte(CH_QUOTE);
                    send_text(klen);
                    send_byte(CH_QUOTE);
                    if ($urandom_range(3) == 0) send_byte(rand_other(CH_QUOTE, CH_QUOTE));
                    send_byte(CH_QUOTE);
                    send_text(vlen);
                    send_byte(CH_QUOTE);
                end
                send_byte(CH_RBRACE);
                if ($urandom_range(2) == 0) send_byte(rand_other(CH_LBRACE, CH_LBRACE));
            end
            // Sometimes a zero byte halts the lump, followed by a few bytes.
            if ($urandom_range(3) == 0) begin
                send_byte(CH_NUL);
                repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(255)));
            end
        end
    endtask

    // Reset, stimulus phases and verdict.
    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Sender idles little, receiver stalls a lot.
        send_idle_pct = 26;
        recv_idle_pct = 84;
        for (int i = 0; i < N_DIRECTED; i++) begin
            restart_next = DIRECTED[i][8];
            send_byte(DIRECTED[i][7:0]);
        end
        send_lump(255, -1);
        while (n_sent < N_RANDOM / 3) send_lump(-1, -1);

        // Sender idles a lot, receiver stalls little.
        send_idle_pct = 84;
        recv_idle_pct = 26;
        send_lump(256, -1);
        while (n_sent < 2 * N_RANDOM / 3) send_lump(-1, -1);

        // No idling: the rest of the random part.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (n_sent < N_RANDOM) send_lump(-1, -1);

        snd_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
sv/ett_pkg.sv
sv/ett_if.sv
sv/ett_front.sv
sv/ett_fifo.sv
sv/ett_back.sv
sv/entity_text_tokenizer_unit.sv
dv/entity_text_tokenizer_unit_checker.sv
dv/entity_text_tokenizer_unit_tb.sv
